/* hw/rtl/bmsl_pkg.sv */
// Shared types, constants and a helper function for the bounded sorted match list.
`default_nettype none

package bmsl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int OFS_W  = 10;
  localparam int DIST_W = 24;
  localparam int RANK_W = 6;
  localparam int KEPT_W = 7;
  localparam int LOG_W  = 3;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_ORIGIN     = 3'd1,
    ST_TOO_FAR    = 3'd2,
    ST_NOT_BETTER = 3'd3,
    ST_STARTED    = 3'd4,
    ST_ENTRY      = 3'd5
  } status_t;

  typedef struct packed {
    logic signed [OFS_W-1:0] x;
    logic signed [OFS_W-1:0] y;
    logic [DIST_W-1:0]       distance;
  } entry_t;

  typedef struct packed {
    logic start;
    logic insert;
    logic rotate;
  } cell_cmd_t;

  // Floor of the base two logarithm; zero for zero.
  function automatic logic [LOG_W-1:0] flog2(input logic [CNT_W-1:0] n);
    logic [LOG_W-1:0] lg;
    lg = '0;
    for (int b = 0; b < CNT_W; b++) begin
      if (n[b]) begin
        lg = LOG_W'(b);
      end
    end
    return lg;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bmsl_cell.sv */
// One position of the sorted candidate list: holds an entry and shifts or rotates it.
`default_nettype none

module bmsl_cell (
  input  wire                          clk,
  input  bmsl_pkg::cell_cmd_t          cmd,
  input  bmsl_pkg::entry_t             new_ent,
  input  bmsl_pkg::entry_t             left_ent,
  input  bmsl_pkg::entry_t             right_ent,
  input  wire                          left_ge,
  input  wire [bmsl_pkg::IDX_W-1:0]    idx,
  input  wire [bmsl_pkg::CNT_W-1:0]    count,
  output bmsl_pkg::entry_t             ent,
  output logic                         ge
);
  import bmsl_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   occupied;

  assign occupied = {1'b0, idx} < count;
  // The candidate stays behind this entry when its distance is equal or larger.
  assign ge       = occupied && (new_ent.distance >= ent_r.distance);
  assign ent      = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.start) begin
      if (idx == '0) begin
        ent_nxt = '0;
      end
    end else if (cmd.insert) begin
      if (!ge) begin
        ent_nxt = left_ge ? new_ent : left_ent;
      end
    end else if (cmd.rotate) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/bounded_sorted_match_list.sv */
// Top level of the bounded sorted match list: sequencer, cell chain and output register.
//
//  channel | dir | handshake          | contents
//  in_     | in  | in_tvalid/tready   | tuser: op; tdata: offset_x, offset_y, distance
//  out_    | out | out_tvalid/tready  | tuser: status; tlast: last; tdata: entry fields
//  cfg_    | in  | cfg_we             | cfg_wdata: distance_limit
//
// A start or insert is registered and then all cells compare against the candidate and
// shift in parallel; an unused item is registered and dropped.
// A readout of a non-empty list rotates the chain once around its full length through
// cell 0, which feeds the output register, so the list order is restored. A readout of
// an empty list gives no output.
// Rotation of a listed entry, and the compare and shift of a start or insert, pause while
// the output register holds a result that is not taken.
// Reset is synchronous; it empties the list and sets the limit to its maximum.
`default_nettype none

module bounded_sorted_match_list (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [47:0] in_tdata,   // offset_x[9:0], offset_y[19:10], distance[43:20], zeros
  input  wire  [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // entry_x[9:0], entry_y[19:10], entry_distance[43:20],
                                  // entry_rank[49:44], kept_count[56:50],
                                  // log_count[59:57], zeros
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast,
  input  wire         cfg_we,
  input  wire  [23:0] cfg_wdata
);
  import bmsl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_READ = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [DIST_W-1:0]  limit_r;
  op_t                op_r;
  entry_t             cand_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   rank_r, rank_nxt;
  logic [LOG_W-1:0]   log_r, log_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  entry_t             out_ent_r, out_ent_nxt;
  logic [RANK_W-1:0]  out_rank_r, out_rank_nxt;
  logic [KEPT_W-1:0]  out_kept_r, out_kept_nxt;
  logic [LOG_W-1:0]   out_log_r, out_log_nxt;
  logic               out_last_r, out_last_nxt;

  cell_cmd_t          cmd;
  entry_t             ent      [MAX_ENTRIES];
  entry_t             left_ent [MAX_ENTRIES];
  entry_t             right_ent[MAX_ENTRIES];
  logic               ge       [MAX_ENTRIES];
  logic               left_ge  [MAX_ENTRIES];
  logic               slot_free;
  logic               in_accept;
  logic               is_full;
  logic               sorted_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign is_full   = (count_r == CNT_W'(MAX_ENTRIES));

  // Neighbor wiring of the chain; cell 0 always counts as the insertion head.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      left_ent[i]  = (i == 0) ? cand_r : ent[(i == 0) ? 0 : i - 1];
      left_ge[i]   = (i == 0) ? 1'b1   : ge[(i == 0) ? 0 : i - 1];
      right_ent[i] = ent[(i == MAX_ENTRIES - 1) ? 0 : i + 1];
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    bmsl_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_ent   (cand_r),
      .left_ent  (left_ent[g]),
      .right_ent (right_ent[g]),
      .left_ge   (left_ge[g]),
      .idx       (IDX_W'(g)),
      .count     (count_r),
      .ent       (ent[g]),
      .ge        (ge[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rank_nxt       = rank_r;
    log_nxt        = log_r;
    cmd            = '0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_rank_nxt   = out_rank_r;
    out_kept_nxt   = out_kept_r;
    out_log_nxt    = out_log_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          OP_START, OP_INSERT: begin
            if (slot_free) begin
              out_valid_nxt = 1'b1;
              out_ent_nxt   = '0;
              out_rank_nxt  = '0;
              out_log_nxt   = '0;
              out_last_nxt  = 1'b1;
              state_nxt     = S_IDLE;
              if (op_r == OP_START) begin
                cmd.start      = 1'b1;
                count_nxt      = CNT_W'(1);
                out_status_nxt = ST_STARTED;
              end else if (cand_r.x == '0 && cand_r.y == '0) begin
                out_status_nxt = ST_ORIGIN;
              end else if (cand_r.distance > limit_r) begin
                out_status_nxt = ST_TOO_FAR;
              end else if (is_full && ge[MAX_ENTRIES-1]) begin
                out_status_nxt = ST_NOT_BETTER;
              end else begin
                cmd.insert     = 1'b1;
                out_status_nxt = ST_INSERTED;
                if (!is_full) begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              out_kept_nxt = KEPT_W'(count_nxt);
            end
          end
          OP_READ: begin
            if (count_r == '0) begin
              state_nxt = S_IDLE;
            end else begin
              log_nxt   = flog2(count_r);
              count_nxt = CNT_W'(1) << flog2(count_r);
              rank_nxt  = '0;
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        // Entries past the kept count still rotate by to restore the order.
        if (({1'b0, rank_r} >= count_r) || slot_free) begin
          cmd.rotate = 1'b1;
          if ({1'b0, rank_r} < count_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_ENTRY;
            out_ent_nxt    = ent[0];
            out_rank_nxt   = RANK_W'(rank_r);
            out_kept_nxt   = KEPT_W'(count_r);
            out_log_nxt    = log_r;
            out_last_nxt   = ({1'b0, rank_r} == count_r - CNT_W'(1));
          end
          if (rank_r == IDX_W'(MAX_ENTRIES - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            rank_nxt = rank_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      limit_r     <= '1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r            <= op_t'(in_tuser);
      cand_r.x        <= in_tdata[9:0];
      cand_r.y        <= in_tdata[19:10];
      cand_r.distance <= in_tdata[43:20];
    end
    rank_r       <= rank_nxt;
    log_r        <= log_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_rank_r   <= out_rank_nxt;
    out_kept_r   <= out_kept_nxt;
    out_log_r    <= out_log_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0, out_log_r, out_kept_r, out_rank_r,
                       out_ent_r.distance, out_ent_r.y, out_ent_r.x};

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
      if ((CNT_W'(i + 1) < count_r) && (ent[i].distance > ent[i+1].distance)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above list capacity");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> sorted_ok)
    else $error("stored entries out of distance order");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("second item taken while one is in work");

  a_entry_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_ENTRY) |-> (KEPT_W'(out_rank_r) < out_kept_r))
    else $error("listed rank beyond kept count");

  a_entry_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_ENTRY) |-> $onehot(out_kept_r))
    else $error("readout count is not a power of two");

endmodule

`default_nettype wire
